FILE: design/bbm_pkg.sv
// Shared types, operation codes and small arithmetic helpers of the background masker.
// No dependencies; every other design file imports this package.
package bbm_pkg;

    localparam int IDX_W = 16;
    localparam int PIX_W = 8;
    localparam int SUM_W = 16;
    localparam int THR_W = 15;
    localparam int CNT_W = 17;
    localparam int FRM_W = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [THR_W-1:0] THR_RESET = 15'd3200;
    localparam logic [CNT_W-1:0] CNT_RESET = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_COUNT = 1'd1;

    localparam logic [1:0] KIND_BG    = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_TEST  = 2'd2;

    typedef enum logic [1:0] {
        OP_BG    = 2'd0,
        OP_CLOSE = 2'd1,
        OP_TEST  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] pixel_index;
        logic [PIX_W-1:0] pixel_c0;
        logic [PIX_W-1:0] pixel_c1;
        logic [PIX_W-1:0] pixel_c2;
        logic             group_last;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [PIX_W-1:0] out_c0;
        logic [PIX_W-1:0] out_c1;
        logic [PIX_W-1:0] out_c2;
        logic             masked;
        logic             last;
        logic             error;
    } t_out_item;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_q_item;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CNT_W-1:0]     data;
    } t_cfg_wr;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // x / 3 for x < 256: multiply by 171 and drop nine bits
    function automatic logic [PIX_W-1:0] div3(input logic [PIX_W-1:0] x);
        logic [PIX_W+8:0] p;
        p = {9'd0, x} * 17'd171;
        return p[PIX_W+8:9];
    endfunction

endpackage

FILE: design/bbm_front.sv
// Front end: accepts input beats, decodes the kind into an operation and queues it.
// Depends on bbm_pkg. Unused kinds are taken and dropped here.
module bbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bbm_pkg::t_in_item i_data,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output bbm_pkg::t_q_item  o_q_data
);
    import bbm_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW = 2;

    t_q_item        r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           push, pop, take;
    t_q_item        entry;

    assign o_stall   = (r_cnt == (PW+1)'(DEPTH));
    assign take      = i_valid && !o_stall;
    assign push      = take && (i_data.kind == KIND_BG || i_data.kind == KIND_CLOSE
                                || i_data.kind == KIND_TEST);
    assign o_q_valid = (r_cnt != '0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_data  = r_mem[r_rp];

    always_comb begin
        entry.item = i_data;
        case (i_data.kind)
            KIND_BG:    entry.op = OP_BG;
            KIND_CLOSE: entry.op = OP_CLOSE;
            default:    entry.op = OP_TEST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

FILE: design/bbm_back.sv
// Back end: sum and mean stores, close walk with a serial divider, tile scoring
// and tile emission through an output register. Depends on bbm_pkg.
module bbm_back #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_FRAMES = 256,
    parameter int TILE_SIDE  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbm_pkg::t_cfg_wr   i_cfg,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  bbm_pkg::t_q_item   i_q_data,
    output logic               o_valid,
    input  logic               i_stall,
    output bbm_pkg::t_out_item o_data
);
    import bbm_pkg::*;

    localparam int AW   = $clog2(MAX_PIXELS);
    localparam int PW   = $clog2(MAX_PIXELS + 1);
    localparam int TP   = TILE_SIDE * TILE_SIDE;
    localparam int TW   = $clog2(TP);
    localparam int FW   = $clog2(TP + 1);
    localparam bit NEED_RED = (MAX_PIXELS < 65536);
    localparam logic [35:0] MP36 = 36'(MAX_PIXELS);
    localparam logic [20:0] MP21 = 21'(MAX_PIXELS);
    localparam logic [FRM_W-1:0] MAXF = FRM_W'(MAX_FRAMES);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RED   = 13'b0000000000010,
        S_BG_RD = 13'b0000000000100,
        S_BG_WR = 13'b0000000001000,
        S_CL_RD = 13'b0000000010000,
        S_CL_LD = 13'b0000000100000,
        S_CL_DV = 13'b0000001000000,
        S_CL_WR = 13'b0000010000000,
        S_T_RD  = 13'b0000100000000,
        S_T_CL  = 13'b0001000000000,
        S_EM_RD = 13'b0010000000000,
        S_EM_OT = 13'b0100000000000,
        S_STAT  = 13'b1000000000000
    } t_state;

    t_state r_st, n_st;

    logic [THR_W-1:0]  r_thr;
    logic [CNT_W-1:0]  r_pcnt;
    logic [FRM_W-1:0]  r_frames;
    logic              r_model;
    logic [FW-1:0]     r_fill;
    logic [THR_W-1:0]  r_score;
    t_q_item           r_it;
    logic [IDX_W-1:0]  r_rem;
    logic [3:0]        r_k;
    logic [PW-1:0]     r_p, r_n;
    logic [SUM_W-1:0]  r_dq [3];
    logic [FRM_W-1:0]  r_rm [3];
    logic [4:0]        r_dcnt;
    logic [TW-1:0]     r_em;
    logic [FW-1:0]     r_emn;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [3*SUM_W-1:0] sum_mem [MAX_PIXELS];
    logic [3*PIX_W-1:0] mean_mem [MAX_PIXELS];
    logic [IDX_W+3*PIX_W-1:0] tile_mem [TP];
    logic [3*SUM_W-1:0] r_sum_q;
    logic [3*PIX_W-1:0] r_mean_q;
    logic [IDX_W+3*PIX_W-1:0] r_tb_q;

    logic [AW-1:0]      addr;
    logic               out_free, out_load;
    t_out_item          out_next;
    logic               sum_we, mean_we, tb_we;
    logic [3*SUM_W-1:0] sum_wd;
    logic [3*PIX_W-1:0] mean_wd;
    logic [35:0]        red_cmp;
    logic [20:0]        pc21;
    logic [PIX_W-1:0]   smp [3];
    logic [THR_W-1:0]   pix_score, new_score;
    logic [FW-1:0]      fill_inc;
    logic [SUM_W-1:0]   nq [3];
    logic [FRM_W-1:0]   nr [3];
    logic               blank;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign o_q_ready = (r_st == S_IDLE);
    assign addr      = (r_st == S_CL_RD || r_st == S_CL_WR) ? AW'(r_p) : AW'(r_rem);
    assign red_cmp   = MP36 << r_k;
    assign pc21      = 21'(r_pcnt);
    assign smp[0]    = r_it.item.pixel_c0;
    assign smp[1]    = r_it.item.pixel_c1;
    assign smp[2]    = r_it.item.pixel_c2;
    assign fill_inc  = r_fill + 1'b1;
    assign blank     = (r_score <= r_thr);

    always_comb begin
        pix_score = THR_W'(abs_diff(r_mean_q[3*PIX_W-1:2*PIX_W], smp[0]))
                  + THR_W'(div3(abs_diff(r_mean_q[2*PIX_W-1:PIX_W], smp[1])))
                  + THR_W'(div3(abs_diff(r_mean_q[PIX_W-1:0], smp[2])));
        new_score = r_score + pix_score;
    end

    // sample write on the first frame, saturating add afterward
    always_comb begin
        logic [SUM_W:0] s;
        for (int c = 0; c < 3; c++) begin
            s = {1'b0, r_sum_q[(2-c)*SUM_W +: SUM_W]} + (SUM_W+1)'(smp[c]);
            if (r_frames == '0) begin
                sum_wd[(2-c)*SUM_W +: SUM_W] = SUM_W'(smp[c]);
            end else if (s[SUM_W]) begin
                sum_wd[(2-c)*SUM_W +: SUM_W] = '1;
            end else begin
                sum_wd[(2-c)*SUM_W +: SUM_W] = s[SUM_W-1:0];
            end
        end
    end

    // one restoring division step per channel
    always_comb begin
        logic [FRM_W:0] t;
        for (int c = 0; c < 3; c++) begin
            t = {r_rm[c], r_dq[c][SUM_W-1]};
            if (t >= {1'b0, r_frames}) begin
                nr[c] = FRM_W'(t - {1'b0, r_frames});
                nq[c] = {r_dq[c][SUM_W-2:0], 1'b1};
            end else begin
                nr[c] = t[FRM_W-1:0];
                nq[c] = {r_dq[c][SUM_W-2:0], 1'b0};
            end
        end
        mean_wd = {r_dq[0][PIX_W-1:0], r_dq[1][PIX_W-1:0], r_dq[2][PIX_W-1:0]};
    end

    always_comb begin
        sum_we   = (r_st == S_BG_WR);
        mean_we  = (r_st == S_CL_WR);
        tb_we    = (r_st == S_T_CL);
        out_load = 1'b0;
        out_next = '0;
        if (r_st == S_STAT && out_free) begin
            out_load      = 1'b1;
            out_next.last = 1'b1;
            out_next.error = 1'b1;
        end else if (r_st == S_EM_OT && out_free) begin
            out_load           = 1'b1;
            out_next.out_index = r_tb_q[IDX_W+3*PIX_W-1:3*PIX_W];
            out_next.out_c0    = blank ? '0 : r_tb_q[3*PIX_W-1:2*PIX_W];
            out_next.out_c1    = blank ? '0 : r_tb_q[2*PIX_W-1:PIX_W];
            out_next.out_c2    = blank ? '0 : r_tb_q[PIX_W-1:0];
            out_next.masked    = blank;
            out_next.last      = (FW'(r_em) + 1'b1 == r_emn);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_q  <= sum_mem[addr];
        r_mean_q <= mean_mem[addr];
        r_tb_q   <= tile_mem[r_em];
        if (sum_we)  sum_mem[addr]  <= sum_wd;
        if (mean_we) mean_mem[addr] <= mean_wd;
        if (tb_we) begin
            tile_mem[TW'(r_fill)] <= {r_it.item.pixel_index, smp[0], smp[1], smp[2]};
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_data.op)
                        OP_BG: begin
                            if (r_frames != MAXF) n_st = NEED_RED ? S_RED : S_BG_RD;
                        end
                        OP_CLOSE: begin
                            if (r_frames != '0)  n_st = S_CL_RD;
                            else if (!r_model)   n_st = S_STAT;
                        end
                        default: begin
                            n_st = !r_model ? S_STAT : (NEED_RED ? S_RED : S_T_RD);
                        end
                    endcase
                end
            end
            S_RED:   if (r_k == '0) n_st = (r_it.op == OP_BG) ? S_BG_RD : S_T_RD;
            S_BG_RD: n_st = S_BG_WR;
            S_BG_WR: n_st = S_IDLE;
            S_CL_RD: n_st = (r_n == '0) ? S_IDLE : S_CL_LD;
            S_CL_LD: n_st = S_CL_DV;
            S_CL_DV: if (r_dcnt == 5'd1) n_st = S_CL_WR;
            S_CL_WR: n_st = (r_p + 1'b1 == r_n) ? S_IDLE : S_CL_RD;
            S_T_RD:  n_st = S_T_CL;
            S_T_CL:  n_st = (r_it.item.group_last || fill_inc == FW'(TP)) ? S_EM_RD : S_IDLE;
            S_EM_RD: n_st = S_EM_OT;
            S_EM_OT: begin
                if (out_free) n_st = (FW'(r_em) + 1'b1 == r_emn) ? S_IDLE : S_EM_RD;
            end
            S_STAT:  if (out_free) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_thr       <= THR_RESET;
            r_pcnt      <= CNT_RESET;
            r_frames    <= '0;
            r_model     <= 1'b0;
            r_fill      <= '0;
            r_score     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_out_valid <= out_load || (r_out_valid && i_stall);
            if (i_cfg.we && i_cfg.idx == CFG_THRESHOLD) r_thr  <= i_cfg.data[THR_W-1:0];
            if (i_cfg.we && i_cfg.idx == CFG_PIX_COUNT) r_pcnt <= i_cfg.data;
            if (r_st == S_BG_WR && r_it.item.group_last) r_frames <= r_frames + 1'b1;
            if ((r_st == S_CL_RD && r_n == '0)
                || (r_st == S_CL_WR && r_p + 1'b1 == r_n)) begin
                r_model  <= 1'b1;
                r_frames <= '0;
            end
            if (r_st == S_T_CL) begin
                r_fill  <= fill_inc;
                r_score <= new_score;
            end
            if (r_st == S_EM_OT && out_free && FW'(r_em) + 1'b1 == r_emn) begin
                r_fill  <= '0;
                r_score <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= out_next;
        case (r_st)
            S_IDLE: begin
                r_it  <= i_q_data;
                r_rem <= i_q_data.item.pixel_index;
                r_k   <= 4'd15;
                r_p   <= '0;
                r_n   <= (pc21 > MP21) ? PW'(MAX_PIXELS) : PW'(r_pcnt);
            end
            S_RED: begin
                if ({20'd0, r_rem} >= red_cmp) r_rem <= r_rem - red_cmp[IDX_W-1:0];
                r_k <= r_k - 1'b1;
            end
            S_CL_LD: begin
                for (int c = 0; c < 3; c++) begin
                    r_dq[c] <= r_sum_q[(2-c)*SUM_W +: SUM_W];
                    r_rm[c] <= '0;
                end
                r_dcnt <= 5'd16;
            end
            S_CL_DV: begin
                for (int c = 0; c < 3; c++) begin
                    r_dq[c] <= nq[c];
                    r_rm[c] <= nr[c];
                end
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_CL_WR: r_p <= r_p + 1'b1;
            S_T_CL: begin
                r_em  <= '0;
                r_emn <= fill_inc;
            end
            S_EM_OT: if (out_free) r_em <= r_em + 1'b1;
            default: ;
        endcase
    end

endmodule

FILE: design/block_background_masker.sv
// Top level of the background masker: front queue plus back end.
// Depends on bbm_pkg, bbm_front and bbm_back.
//
//   port group      direction  handshake        payload
//   input beat      in         i_valid/o_stall  i_data  (t_in_item)
//   result beat     out        o_valid/i_stall  o_data  (t_out_item)
//   register write  in         i_cfg_we         i_cfg_idx, i_cfg_data
//
// Background pixel: sum read then write (after index folding when MAX_PIXELS < 65536).
// Close: per pixel walked, a sum read, a load, the 16-step serial divider and a mean write.
// Test pixel: mean read, then scoring; a tile then drains, each result read then output.
// Reset is synchronous; stores power up undefined and need no clearing pass.
// A stalled output holds the back end at its next result; the four-entry queue still fills.
module block_background_masker #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_FRAMES = 256,
    parameter int TILE_SIDE  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  bbm_pkg::t_in_item                   i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output bbm_pkg::t_out_item                  o_data,
    input  logic                                i_cfg_we,
    input  logic [bbm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bbm_pkg::CNT_W-1:0]           i_cfg_data
);
    import bbm_pkg::*;

    logic    q_valid, q_ready;
    t_q_item q_data;
    t_cfg_wr cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    bbm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_data  (q_data)
    );

    bbm_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_FRAMES (MAX_FRAMES),
        .TILE_SIDE  (TILE_SIDE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_data  (q_data),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error |-> o_data.last && !o_data.masked)
        else $error("status beat without last or with mask");

    a_mask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.masked |-> o_data.out_c0 == '0 && o_data.out_c1 == '0
                                     && o_data.out_c2 == '0)
        else $error("masked beat carries pixel data");

    a_err_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error |-> o_data.out_index == '0)
        else $error("status beat with nonzero index");

endmodule
